/* sv/pcct_pkg.sv */
// Package for the pausable chronometer/countdown timer.
// Holds command codes, timing constants and the stage payload types.
// No dependencies; every other file uses it by scoped names.
`default_nettype none

package pcct_pkg;

   // Command codes on req_mode
   localparam logic [3:0] MODE_SET_INIT     = 4'd0;
   localparam logic [3:0] MODE_ADD_OFFSET   = 4'd1;
   localparam logic [3:0] MODE_START        = 4'd2;
   localparam logic [3:0] MODE_START_PAUSED = 4'd3;
   localparam logic [3:0] MODE_PAUSE        = 4'd4;
   localparam logic [3:0] MODE_CONTINUE     = 4'd5;
   localparam logic [3:0] MODE_RESET        = 4'd6;
   localparam logic [3:0] MODE_READ         = 4'd7;
   localparam logic [3:0] MODE_EDGE_QUERY   = 4'd8;

   // Milliseconds per second and its reciprocal: x / 1000 == (x * RECIP) >> 38
   // for every 32-bit unsigned x.
   localparam logic [31:0] MS_PER_SEC  = 32'd1000;
   localparam logic [10:0] MS_PER_SEC11 = 11'd1000;
   localparam logic [28:0] RECIP       = 29'd274877907;
   localparam int          RECIP_SHIFT = 38;
   localparam int          PROD_W      = 61;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

   // One accepted request
   typedef struct packed {
      logic [3:0]  mode;
      logic [31:0] now_ms;
      logic [31:0] value_ms;
      logic [9:0]  window_ms;
      logic        want_rising;
      logic        want_falling;
   } cmd_type;

   // Timer value after the command, with what the window math needs
   typedef struct packed {
      logic [31:0] time_ms;
      logic [9:0]  window_ms;
      logic        edge_query;
      logic        want_rising;
      logic        want_falling;
      logic        running;
      logic        paused;
   } timed_type;

endpackage

`default_nettype wire

/* sv/pcct_state.sv */
// Timer state stage: applies one command to the marks and flags and
// registers the resulting timer value. Depends on pcct_pkg.
`default_nettype none

module pcct_state (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire pcct_pkg::cmd_type    in_cmd,
   output logic                      in_stall,
   output logic                      out_valid,
   output pcct_pkg::timed_type       out_data,
   input  wire logic                 out_stall
);

   logic [31:0] init_time_ff, init_time_in;
   logic [31:0] start_mark_ff, start_mark_in;
   logic [31:0] pause_mark_ff, pause_mark_in;
   logic        started_ff, started_in;
   logic        paused_ff, paused_in;
   logic        valid_ff;
   pcct_pkg::timed_type data_ff, data_in;
   logic        advance;
   logic        take;

   assign advance  = !valid_ff || !out_stall;
   assign take     = in_valid && advance;
   assign in_stall = !advance;

   // Apply the command to the timer state
   always_comb begin
      init_time_in  = init_time_ff;
      start_mark_in = start_mark_ff;
      pause_mark_in = pause_mark_ff;
      started_in    = started_ff;
      paused_in     = paused_ff;
      unique case (in_cmd.mode)
         pcct_pkg::MODE_SET_INIT: begin
            init_time_in = in_cmd.value_ms;
         end
         pcct_pkg::MODE_ADD_OFFSET: begin
            if (started_ff) begin
               start_mark_in = start_mark_ff - in_cmd.value_ms;
            end else begin
               init_time_in = init_time_ff + in_cmd.value_ms;
            end
         end
         pcct_pkg::MODE_START: begin
            start_mark_in = in_cmd.now_ms - init_time_ff;
            started_in    = 1'b1;
            paused_in     = 1'b0;
         end
         pcct_pkg::MODE_START_PAUSED: begin
            start_mark_in = in_cmd.now_ms - init_time_ff;
            started_in    = 1'b1;
            paused_in     = 1'b1;
            pause_mark_in = in_cmd.now_ms;
         end
         pcct_pkg::MODE_PAUSE: begin
            if (!paused_ff) begin
               pause_mark_in = in_cmd.now_ms;
            end
            paused_in = 1'b1;
         end
         pcct_pkg::MODE_CONTINUE: begin
            if (paused_ff) begin
               start_mark_in = in_cmd.now_ms - (pause_mark_ff - start_mark_ff);
            end
            paused_in = 1'b0;
         end
         pcct_pkg::MODE_RESET: begin
            started_in = 1'b0;
            paused_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Timer value as it stands after the command
   always_comb begin
      if (!started_in) begin
         data_in.time_ms = init_time_in;
      end else if (paused_in) begin
         data_in.time_ms = pause_mark_in - start_mark_in;
      end else begin
         data_in.time_ms = in_cmd.now_ms - start_mark_in;
      end
      data_in.window_ms    = in_cmd.window_ms;
      data_in.edge_query   = (in_cmd.mode == pcct_pkg::MODE_EDGE_QUERY);
      data_in.want_rising  = in_cmd.want_rising;
      data_in.want_falling = in_cmd.want_falling;
      data_in.running      = started_in;
      data_in.paused       = paused_in;
   end

   // Commit state and result only when the request moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         init_time_ff  <= '0;
         start_mark_ff <= '0;
         pause_mark_ff <= '0;
         started_ff    <= 1'b0;
         paused_ff     <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            init_time_ff  <= init_time_in;
            start_mark_ff <= start_mark_in;
            pause_mark_ff <= pause_mark_in;
            started_ff    <= started_in;
            paused_ff     <= paused_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/pcct_window.sv */
// Window and output stages: magnitude, reciprocal divide by 1000,
// remainder window test, edge tracking and the result register.
// Depends on pcct_pkg.
`default_nettype none

module pcct_window (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire pcct_pkg::timed_type  in_data,
   output logic                      in_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_time_ms,
   output logic                      rsp_not_positive,
   output logic        [31:0]        rsp_remaining_ms,
   output logic                      rsp_in_window,
   output logic                      rsp_edge_seen,
   output logic                      rsp_running_flag,
   output logic                      rsp_paused_flag
);

   typedef struct packed {
      pcct_pkg::timed_type base;
      logic [31:0]         mag;
      logic                positive;
      logic                not_positive;
      logic [31:0]         remaining;
   } mag_type;

   typedef struct packed {
      mag_type                        m;
      logic [pcct_pkg::QUOT_W-1:0]    quot;
   } quot_type;

   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   logic     a_adv, b_adv, c_adv;
   mag_type  a_ff, a_in;
   quot_type b_ff, b_in;
   logic [31:0]           neg_time;
   logic                  negative;
   logic [pcct_pkg::PROD_W-1:0] product;
   logic [31:0]           quot_k;
   logic [31:0]           rem_full;
   logic [9:0]            rem;
   logic                  inw;
   logic                  edge_hit;
   logic                  last_in_window_ff;
   logic [31:0]           time_ff;
   logic                  not_positive_ff;
   logic [31:0]           remaining_ff;
   logic                  in_window_ff;
   logic                  edge_seen_ff;
   logic                  running_ff;
   logic                  paused_ff;

   // Stage handshake: a stage moves when it is empty or its successor moves
   assign c_adv    = !c_valid_ff || !rsp_stall;
   assign b_adv    = !b_valid_ff || c_adv;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_stall = !a_adv;

   // Sign split and magnitude
   always_comb begin
      negative        = in_data.time_ms[31];
      neg_time        = 32'd0 - in_data.time_ms;
      a_in.base       = in_data;
      a_in.positive   = !negative && (in_data.time_ms != 32'd0);
      a_in.not_positive = !a_in.positive;
      a_in.mag        = negative ? neg_time : in_data.time_ms;
      a_in.remaining  = a_in.positive ? 32'd0 : neg_time;
   end

   // Quotient by 1000 through the reciprocal
   always_comb begin
      product = {29'd0, a_ff.mag} * {32'd0, pcct_pkg::RECIP};
      b_in.m    = a_ff;
      b_in.quot = product[pcct_pkg::PROD_W-1:pcct_pkg::RECIP_SHIFT];
   end

   // Remainder, window test and edge qualification
   always_comb begin
      quot_k   = {{(32-pcct_pkg::QUOT_W){1'b0}}, b_ff.quot} * pcct_pkg::MS_PER_SEC;
      rem_full = b_ff.m.mag - quot_k;
      rem      = rem_full[9:0];
      if (b_ff.m.positive) begin
         inw = (rem <= b_ff.m.base.window_ms);
      end else begin
         inw = (({1'b0, rem} + {1'b0, b_ff.m.base.window_ms}) >= pcct_pkg::MS_PER_SEC11);
      end
      edge_hit = b_ff.m.base.edge_query && (inw != last_in_window_ff) &&
                 ((b_ff.m.base.want_rising && b_ff.m.base.want_falling) ||
                  (b_ff.m.base.want_rising && inw) ||
                  (b_ff.m.base.want_falling && !inw));
   end

   // Valid bits and the remembered window state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff        <= 1'b0;
         b_valid_ff        <= 1'b0;
         c_valid_ff        <= 1'b0;
         last_in_window_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= in_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_adv) begin
            c_valid_ff <= b_valid_ff;
         end
         if (c_adv && b_valid_ff && b_ff.m.base.edge_query) begin
            last_in_window_ff <= inw;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (a_adv && in_valid) begin
         a_ff <= a_in;
      end
      if (b_adv && a_valid_ff) begin
         b_ff <= b_in;
      end
      if (c_adv && b_valid_ff) begin
         time_ff         <= b_ff.m.base.time_ms;
         not_positive_ff <= b_ff.m.not_positive;
         remaining_ff    <= b_ff.m.remaining;
         in_window_ff    <= inw;
         edge_seen_ff    <= edge_hit;
         running_ff      <= b_ff.m.base.running;
         paused_ff       <= b_ff.m.base.paused;
      end
   end

   assign rsp_valid        = c_valid_ff;
   assign rsp_time_ms      = $signed(time_ff);
   assign rsp_not_positive = not_positive_ff;
   assign rsp_remaining_ms = remaining_ff;
   assign rsp_in_window    = in_window_ff;
   assign rsp_edge_seen    = edge_seen_ff;
   assign rsp_running_flag = running_ff;
   assign rsp_paused_flag  = paused_ff;

endmodule

`default_nettype wire

/* sv/pausable_chrono_countdown_timer.sv */
// Pausable chronometer / countdown timer, top level.
// Instantiates pcct_state and pcct_window; uses pcct_pkg.
//
// Signed millisecond timer driven by commands that each carry the current
// free-running millisecond count. Every request returns one response with the
// timer value after the command, the not-positive flag, the countdown
// remainder, the in-window flag, the edge flag (edge queries only) and the
// running/paused flags. One request is taken every clock cycle while
// req_stall is low; a response passes the input register, state update,
// magnitude, reciprocal multiply for the divide by 1000, then remainder test
// into the response register. Each stage holds its request while the stage
// after it is stalled.
`default_nettype none

module pausable_chrono_countdown_timer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [3:0]  req_mode,
   input  wire logic        [31:0] req_now_ms,
   input  wire logic signed [31:0] req_value_ms,
   input  wire logic        [9:0]  req_window_ms,
   input  wire logic               req_want_rising,
   input  wire logic               req_want_falling,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_time_ms,
   output logic                    rsp_not_positive,
   output logic        [31:0]      rsp_remaining_ms,
   output logic                    rsp_in_window,
   output logic                    rsp_edge_seen,
   output logic                    rsp_running_flag,
   output logic                    rsp_paused_flag
);

   logic                 in_valid_ff;
   pcct_pkg::cmd_type    in_cmd_ff;
   logic                 in_adv;
   logic                 st_stall;
   logic                 st_valid;
   pcct_pkg::timed_type  st_data;
   logic                 win_stall;

   assign in_adv    = !in_valid_ff || !st_stall;
   assign req_stall = !in_adv;

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         in_cmd_ff.mode         <= req_mode;
         in_cmd_ff.now_ms       <= req_now_ms;
         in_cmd_ff.value_ms     <= $unsigned(req_value_ms);
         in_cmd_ff.window_ms    <= req_window_ms;
         in_cmd_ff.want_rising  <= req_want_rising;
         in_cmd_ff.want_falling <= req_want_falling;
      end
   end

   pcct_state u_state (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_cmd    (in_cmd_ff),
      .in_stall  (st_stall),
      .out_valid (st_valid),
      .out_data  (st_data),
      .out_stall (win_stall)
   );

   pcct_window u_window (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (st_valid),
      .in_data          (st_data),
      .in_stall         (win_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_time_ms      (rsp_time_ms),
      .rsp_not_positive (rsp_not_positive),
      .rsp_remaining_ms (rsp_remaining_ms),
      .rsp_in_window    (rsp_in_window),
      .rsp_edge_seen    (rsp_edge_seen),
      .rsp_running_flag (rsp_running_flag),
      .rsp_paused_flag  (rsp_paused_flag)
   );

endmodule

`default_nettype wire

/* test/pausable_chrono_countdown_timer_test.sv */
// Self-checking testbench for the pausable chronometer / countdown timer.
// Drives timer commands, predicts every response in place and compares them.
// Depends on pcct_pkg and pausable_chrono_countdown_timer.
module pausable_chrono_countdown_timer_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected content of one response
   typedef struct packed {
      logic [31:0] time_ms;
      logic        not_positive;
      logic [31:0] remaining_ms;
      logic        in_window;
      logic        edge_seen;
      logic        running;
      logic        paused;
   } reading_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic        [3:0]  req_mode = pcct_pkg::MODE_READ;
   logic        [31:0] req_now_ms = '0;
   logic signed [31:0] req_value_ms = '0;
   logic        [9:0]  req_window_ms = '0;
   logic               req_want_rising = 1'b0;
   logic               req_want_falling = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_time_ms;
   logic               rsp_not_positive;
   logic        [31:0] rsp_remaining_ms;
   logic               rsp_in_window;
   logic               rsp_edge_seen;
   logic               rsp_running_flag;
   logic               rsp_paused_flag;

   // Predicted timer state
   logic [31:0] tmr_base_ms = '0;
   logic [31:0] tmr_start_ms = '0;
   logic [31:0] tmr_pause_ms = '0;
   logic        tmr_started = 1'b0;
   logic        tmr_paused = 1'b0;
   logic        tmr_last_in_window = 1'b0;

   reading_type pending_readings[$];
   reading_type want;
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_order = 0;
   int          hold_left = 0;
   logic [31:0] wall_ms = '0;

   pausable_chrono_countdown_timer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_now_ms       (req_now_ms),
      .req_value_ms     (req_value_ms),
      .req_window_ms    (req_window_ms),
      .req_want_rising  (req_want_rising),
      .req_want_falling (req_want_falling),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_time_ms      (rsp_time_ms),
      .rsp_not_positive (rsp_not_positive),
      .rsp_remaining_ms (rsp_remaining_ms),
      .rsp_in_window    (rsp_in_window),
      .rsp_edge_seen    (rsp_edge_seen),
      .rsp_running_flag (rsp_running_flag),
      .rsp_paused_flag  (rsp_paused_flag)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Window test: start of second for positive time, end of second otherwise
   function automatic logic window_hit(input logic [31:0] t, input logic [9:0] win);
      logic [31:0] mag;
      int          rem;
      if (!t[31] && t != 0)
         return (t % pcct_pkg::MS_PER_SEC) <= {22'd0, win};
      mag = t[31] ? -t : t;
      rem = int'(mag % pcct_pkg::MS_PER_SEC);
      return rem >= 1000 - int'(win);
   endfunction

   // Apply one command to the predicted state and return the response
   function automatic reading_type apply_timer_command(input pcct_pkg::cmd_type c);
      reading_type r;
      logic [31:0] t;
      case (c.mode)
         pcct_pkg::MODE_SET_INIT: tmr_base_ms = c.value_ms;
         pcct_pkg::MODE_ADD_OFFSET: begin
            if (tmr_started)
               tmr_start_ms = tmr_start_ms - c.value_ms;
            else
               tmr_base_ms = tmr_base_ms + c.value_ms;
         end
         pcct_pkg::MODE_START, pcct_pkg::MODE_START_PAUSED: begin
            tmr_start_ms = c.now_ms - tmr_base_ms;
            tmr_started = 1'b1;
            if (c.mode == pcct_pkg::MODE_START_PAUSED) begin
               tmr_paused = 1'b1;
               tmr_pause_ms = c.now_ms;
            end else begin
               tmr_paused = 1'b0;
            end
         end
         pcct_pkg::MODE_PAUSE: begin
            if (!tmr_paused)
               tmr_pause_ms = c.now_ms;
            tmr_paused = 1'b1;
         end
         pcct_pkg::MODE_CONTINUE: begin
            if (tmr_paused)
               tmr_start_ms = c.now_ms - (tmr_pause_ms - tmr_start_ms);
            tmr_paused = 1'b0;
         end
         pcct_pkg::MODE_RESET: begin
            tmr_paused = 1'b0;
            tmr_started = 1'b0;
         end
         default: ;
      endcase
      if (!tmr_started)
         t = tmr_base_ms;
      else if (tmr_paused)
         t = tmr_pause_ms - tmr_start_ms;
      else
         t = c.now_ms - tmr_start_ms;
      r.time_ms = t;
      r.not_positive = t[31] || t == 0;
      r.remaining_ms = r.not_positive ? -t : 32'd0;
      r.in_window = window_hit(t, c.window_ms);
      r.edge_seen = 1'b0;
      if (c.mode == pcct_pkg::MODE_EDGE_QUERY) begin
         r.edge_seen = (r.in_window != tmr_last_in_window) &&
            ((c.want_rising && c.want_falling) || (c.want_rising && r.in_window) ||
             (c.want_falling && !r.in_window));
         tmr_last_in_window = r.in_window;
      end
      r.running = tmr_started;
      r.paused = tmr_paused;
      return r;
   endfunction

   // Offer one request, hold it until accepted, then maybe idle a little
   task automatic send_request(input logic [3:0] mode, input logic [31:0] now,
                               input logic [31:0] value, input logic [9:0] win,
                               input logic rise, input logic fall);
      pcct_pkg::cmd_type c;
      c.mode = mode;
      c.now_ms = now;
      c.value_ms = value;
      c.window_ms = win;
      c.want_rising = rise;
      c.want_falling = fall;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_now_ms <= now;
      req_value_ms <= value;
      req_window_ms <= win;
      req_want_rising <= rise;
      req_want_falling <= fall;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_readings.push_back(apply_timer_command(c));
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Pick a mostly sensible command on an advancing millisecond clock
   task automatic send_random_request();
      int          pick;
      logic [3:0]  mode;
      logic [31:0] value;
      logic [9:0]  win;
      pick = $urandom_range(0, 99);
      if (pick < 8)       mode = pcct_pkg::MODE_SET_INIT;
      else if (pick < 14) mode = pcct_pkg::MODE_ADD_OFFSET;
      else if (pick < 22) mode = pcct_pkg::MODE_START;
      else if (pick < 27) mode = pcct_pkg::MODE_START_PAUSED;
      else if (pick < 37) mode = pcct_pkg::MODE_PAUSE;
      else if (pick < 47) mode = pcct_pkg::MODE_CONTINUE;
      else if (pick < 52) mode = pcct_pkg::MODE_RESET;
      else if (pick < 70) mode = pcct_pkg::MODE_READ;
      else if (pick < 95) mode = pcct_pkg::MODE_EDGE_QUERY;
      else                mode = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 19) == 0)
         wall_ms = $urandom();
      else
         wall_ms = wall_ms + $urandom_range(0, 1500);
      if ($urandom_range(0, 3) == 0)
         value = $urandom();
      else
         value = $urandom_range(0, 20000) - 10000;
      if ($urandom_range(0, 9) == 0)
         win = 10'($urandom_range(0, 1023));
      else
         win = 10'($urandom_range(0, 1000));
      send_request(mode, wall_ms, value, win, 1'($urandom()), 1'($urandom()));
   endtask

   // Receiver: random stalls, or one long hold-off when ordered
   always @(posedge clock) begin
      if (hold_order > 0) begin
         hold_left = hold_order;
         hold_order = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] expd,
                              input logic [31:0] got);
      if (expd !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expd, got);
         mismatches++;
      end
   endtask

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual time %h",
                     $time, rsp_time_ms);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            check_field("time_ms", want.time_ms, rsp_time_ms);
            check_field("not_positive", want.not_positive, rsp_not_positive);
            check_field("remaining_ms", want.remaining_ms, rsp_remaining_ms);
            check_field("in_window", want.in_window, rsp_in_window);
            check_field("edge_seen", want.edge_seen, rsp_edge_seen);
            check_field("running_flag", want.running, rsp_running_flag);
            check_field("paused_flag", want.paused, rsp_paused_flag);
         end
      end
   end

   // Field extremes, every command and the corner cases
   task automatic test_directed();
      send_request(pcct_pkg::MODE_READ, 32'd0, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_SET_INIT, 32'd0, 32'h8000_0000, 10'd1023, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_EDGE_QUERY, 32'd5, 32'd0, 10'd1023, 1'b1, 1'b1);
      send_request(pcct_pkg::MODE_ADD_OFFSET, 32'd9, 32'hFFFF_FFFF, 10'd1000, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_READ, 32'd9, 32'd0, 10'd1000, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_SET_INIT, 32'd10, -32'sd5000, 10'd100, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_START, 32'hFFFF_F000, 32'd0, 10'd100, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_READ, 32'd1200, 32'd0, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_ADD_OFFSET, 32'd1300, 32'd250, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_PAUSE, 32'd1400, 32'd0, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_PAUSE, 32'd1900, 32'd0, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_CONTINUE, 32'd2300, 32'd0, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_CONTINUE, 32'd2400, 32'd0, 10'd500, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_EDGE_QUERY, 32'd2500, 32'd0, 10'd300, 1'b1, 1'b0);
      send_request(pcct_pkg::MODE_EDGE_QUERY, 32'd3000, 32'd0, 10'd300, 1'b0, 1'b1);
      send_request(pcct_pkg::MODE_EDGE_QUERY, 32'd3500, 32'd0, 10'd300, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_RESET, 32'd3600, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_PAUSE, 32'd3700, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_START_PAUSED, 32'd0, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(4'd9, 32'd800, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b1);
      send_request(pcct_pkg::MODE_SET_INIT, 32'd0, 32'h7FFF_FFFF, 10'd0, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_START, 32'hFFFF_FFFF, 32'd0, 10'd1000, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_SET_INIT, 32'd0, 32'd0, 10'd1000, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_START, 32'hFFFF_FFFF, 32'd0, 10'd0, 1'b0, 1'b0);
      send_request(pcct_pkg::MODE_READ, 32'hFFFF_FFFF, 32'd0, 10'd1000, 1'b1, 1'b1);
   endtask

   // Random commands under the given idling on both sides
   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_random_request();
   endtask

   // Hold the response side off long enough to fill the block and stall input
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_order = 200;
      repeat (40) send_random_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 8, 60);
      test_random(300, 60, 8);
      test_backpressure();
      test_random(260, 0, 0);
      req_valid <= 1'b0;
      // Drain, then wait for stray responses
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
